>>> sv/upsd_pkg.sv
`default_nettype none

package upsd_pkg;

   // Raw characters with a meaning of their own
   localparam logic [7:0] EscChar   = 8'h25;
   localparam logic [7:0] SplitChar = 8'h2F;
   localparam int unsigned HexRadix = 16;

   // Command queue between the front and the back
   localparam int unsigned CmdDepth = 4;
   localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
   localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

   // Result queue at the rsp_ ports
   localparam int unsigned RspDepth = 2;
   localparam int unsigned RspPtrW  = $clog2(RspDepth);
   localparam int unsigned RspCntW  = $clog2(RspDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_uri;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       element_last;
   } rsp_type;

   typedef enum logic [3:0] {
      KIND_DATA  = 4'b0001,
      KIND_ESC   = 4'b0010,
      KIND_SPLIT = 4'b0100,
      KIND_END   = 4'b1000
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] raw;
      logic       is_hex;
      logic [3:0] nibble;
   } cmd_type;

endpackage

`default_nettype wire

>>> sv/upsd_front.sv
`default_nettype none

module upsd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire upsd_pkg::req_type req_data,
   output logic                  cmd_valid,
   output upsd_pkg::cmd_type     cmd_head,
   input  wire logic             cmd_take
);

   upsd_pkg::cmd_type              store_ff [upsd_pkg::CmdDepth];
   logic [upsd_pkg::CmdPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [upsd_pkg::CmdPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [upsd_pkg::CmdCntW-1:0]   count_ff, count_in;
   upsd_pkg::cmd_type              cmd_new;
   logic                           accept;

   // Classify the raw character and decode its hex value up front
   always_comb begin
      cmd_new.raw    = req_data.in_byte;
      cmd_new.is_hex = 1'b0;
      cmd_new.nibble = 4'd0;
      if (req_data.in_byte >= 8'h30 && req_data.in_byte <= 8'h39) begin
         cmd_new.is_hex = 1'b1;
         cmd_new.nibble = 4'(req_data.in_byte - 8'h30);
      end else if (req_data.in_byte >= 8'h61 && req_data.in_byte <= 8'h66) begin
         cmd_new.is_hex = 1'b1;
         cmd_new.nibble = 4'(req_data.in_byte - 8'h57);
      end else if (req_data.in_byte >= 8'h41 && req_data.in_byte <= 8'h46) begin
         cmd_new.is_hex = 1'b1;
         cmd_new.nibble = 4'(req_data.in_byte - 8'h37);
      end
      if (req_data.end_of_uri) begin
         cmd_new.kind = upsd_pkg::KIND_END;
      end else if (req_data.in_byte == upsd_pkg::SplitChar) begin
         cmd_new.kind = upsd_pkg::KIND_SPLIT;
      end else if (req_data.in_byte == upsd_pkg::EscChar) begin
         cmd_new.kind = upsd_pkg::KIND_ESC;
      end else begin
         cmd_new.kind = upsd_pkg::KIND_DATA;
      end
   end

   assign req_full  = (count_ff == upsd_pkg::CmdCntW'(upsd_pkg::CmdDepth));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (accept && !cmd_take) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && cmd_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

>>> sv/upsd_back.sv
`default_nettype none

module upsd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire upsd_pkg::cmd_type cmd_head,
   output logic                   cmd_take,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output upsd_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      PH_OUT = 3'b001,
      PH_P1  = 3'b010,
      PH_P2  = 3'b100
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic                          hi_hex_ff, hi_hex_in;
   logic [3:0]                    hi_nib_ff, hi_nib_in;
   logic [7:0]                    held_ff, held_in;
   logic                          held_valid_ff, held_valid_in;

   upsd_pkg::rsp_type             queue_ff [upsd_pkg::RspDepth];
   logic [upsd_pkg::RspPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [upsd_pkg::RspPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [upsd_pkg::RspCntW-1:0]  count_ff, count_in;

   logic                          fire;
   logic                          emit;
   upsd_pkg::rsp_type             emit_data;
   logic                          deq;

   assign fire     = cmd_valid && (count_ff != upsd_pkg::RspCntW'(upsd_pkg::RspDepth));
   assign cmd_take = fire;

   always_comb begin
      phase_in       = phase_ff;
      hi_hex_in      = hi_hex_ff;
      hi_nib_in      = hi_nib_ff;
      held_in        = held_ff;
      held_valid_in  = held_valid_ff;
      emit           = 1'b0;
      emit_data.out_byte     = held_ff;
      emit_data.element_last = 1'b0;
      if (fire) begin
         if (cmd_head.kind == upsd_pkg::KIND_END ||
             cmd_head.kind == upsd_pkg::KIND_SPLIT) begin
            // Close the element: release the held byte as last
            emit                   = held_valid_ff;
            emit_data.element_last = 1'b1;
            held_valid_in          = 1'b0;
            phase_in               = PH_OUT;
            if (cmd_head.kind == upsd_pkg::KIND_END) begin
               hi_hex_in = 1'b0;
               hi_nib_in = 4'd0;
               held_in   = 8'd0;
            end
         end else begin
            unique case (phase_ff)
               PH_P1: begin
                  hi_hex_in = cmd_head.is_hex;
                  hi_nib_in = cmd_head.nibble;
                  phase_in  = PH_P2;
               end
               PH_P2: begin
                  phase_in = PH_OUT;
                  if (hi_hex_ff && cmd_head.is_hex) begin
                     emit          = held_valid_ff;
                     held_in       = {hi_nib_ff, cmd_head.nibble};
                     held_valid_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_OUT;
                  if (cmd_head.kind == upsd_pkg::KIND_ESC) begin
                     phase_in = PH_P1;
                  end else begin
                     emit          = held_valid_ff;
                     held_in       = cmd_head.raw;
                     held_valid_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Result queue
   assign rsp_empty = (count_ff == '0);
   assign deq       = rsp_pop && !rsp_empty;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (emit) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (emit && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!emit && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OUT;
         held_valid_ff <= 1'b0;
         hi_hex_ff     <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         held_valid_ff <= held_valid_in;
         hi_hex_ff     <= hi_hex_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_nib_ff <= hi_nib_in;
      held_ff   <= held_in;
      if (emit) begin
         queue_ff[wr_ptr_ff] <= emit_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/uri_path_split_percent_decode.sv
`default_nettype none

// Channel  | Ports                          | Beat
// ---------+--------------------------------+-----------------------------------
// request  | req_push, req_full, req_data   | one raw URI byte or end-of-URI mark
// response | rsp_pop, rsp_empty, rsp_data   | one decoded byte, last-of-element
//
// One request beat per cycle while req_full is low; the back end retires one
// command per cycle from a four-entry command queue while the result queue has
// room. A decoded byte is released by the next decoded byte, slash or end mark;
// after that releasing beat it passes the command queue and then the two-entry
// result queue before it sits on rsp_data and can be popped.
// Synchronous reset empties both queues and returns the decoder to outside an
// escape with nothing held.
// req_full rises only when the command queue fills, which happens when the
// result queue stays full because rsp_pop is held low.

module uri_path_split_percent_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire upsd_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output upsd_pkg::rsp_type      rsp_data
);

   logic              cmd_valid;
   logic              cmd_take;
   upsd_pkg::cmd_type cmd_head;

   // Front: classify each raw byte and queue it as a command
   upsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take)
   );

   // Back: run escape decoding, hold one byte back, queue results
   upsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/uri_path_split_percent_decode_tb.sv
`default_nettype none

module uri_path_split_percent_decode_tb;

   localparam int unsigned RandomBeats = 700;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned ReportCap   = 40;

   // Where the decoder stands inside a percent escape
   typedef enum logic [1:0] {
      PH_OUTSIDE   = 2'd0,
      PH_GOT_PCT   = 2'd1,
      PH_GOT_FIRST = 2'd2
   } esc_phase_type;

   // Tracks the decoder state and keeps the decoded bytes still owed by the block.
   class element_byte_board;
      esc_phase_type     phase;
      logic [7:0]        hex_first;
      logic [7:0]        held;
      bit                held_ok;
      upsd_pkg::rsp_type owed_bytes[$];
      int unsigned       faults;

      function new();
         phase     = PH_OUTSIDE;
         hex_first = '0;
         held      = '0;
         held_ok   = 1'b0;
         faults    = 0;
      endfunction

      function int unsigned pending();
         return owed_bytes.size();
      endfunction

      // Value of a hex digit, or the radix when the character is none.
      function int unsigned nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return upsd_pkg::HexRadix;
      endfunction

      function void release_held(bit last);
         upsd_pkg::rsp_type r;
         if (held_ok) begin
            r.out_byte     = held;
            r.element_last = last;
            owed_bytes     = {owed_bytes, r};
            held_ok = 1'b0;
         end
      endfunction

      // Release the previously held byte as non-last and hold the new one.
      function void take_decoded(logic [7:0] b);
         release_held(1'b0);
         held    = b;
         held_ok = 1'b1;
      endfunction

      // Advance the decoder by one accepted request beat.
      function void decode_request(upsd_pkg::req_type r);
         logic [7:0]  c;
         int unsigned hi;
         int unsigned lo;
         c = r.in_byte;
         if (r.end_of_uri) begin
            release_held(1'b1);
            phase     = PH_OUTSIDE;
            hex_first = '0;
            held      = '0;
         end else if (c == upsd_pkg::SplitChar) begin
            // A raw slash closes the element even in the middle of an escape
            phase = PH_OUTSIDE;
            release_held(1'b1);
         end else begin
            case (phase)
               PH_GOT_PCT: begin
                  hex_first = c;
                  phase     = PH_GOT_FIRST;
               end
               PH_GOT_FIRST: begin
                  phase = PH_OUTSIDE;
                  hi = nibble_of(hex_first);
                  lo = nibble_of(c);
                  if (hi < upsd_pkg::HexRadix && lo < upsd_pkg::HexRadix)
                     take_decoded(8'(hi * upsd_pkg::HexRadix + lo));
               end
               default: begin
                  phase = PH_OUTSIDE;
                  if (c == upsd_pkg::EscChar) phase = PH_GOT_PCT;
                  else take_decoded(c);
               end
            endcase
         end
      endfunction

      task report(string what);
         if (faults < ReportCap) $display("MISMATCH @%0t: %s", $realtime, what);
         faults++;
      endtask

      // Compare one response beat with the oldest owed byte, field by field.
      task check_decoded(upsd_pkg::rsp_type got);
         upsd_pkg::rsp_type want;
         if (owed_bytes.size() == 0) begin
            report($sformatf("response %h/%0b with nothing owed",
                             got.out_byte, got.element_last));
         end else begin
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.element_last !== want.element_last)
               report($sformatf("element_last %b, want %b on byte %h",
                                got.element_last, want.element_last, want.out_byte));
         end
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   upsd_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   upsd_pkg::rsp_type rsp_data;

   element_byte_board board;
   upsd_pkg::req_type uri_beats[$];
   int unsigned       beats_sent  = 0;
   int unsigned       cycles      = 0;
   bit                send_calm   = 1'b0;
   bit                drained_mid = 1'b0;
   int unsigned       directed_count;
   int unsigned       pop_stall   = 0;
   int unsigned       pop_calm    = 0;
   int unsigned       pop_roll;

   uri_path_split_percent_decode i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop: a hung handshake or missing results end the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("uri_path_split_percent_decode verification failed");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one; none when calm.
   function automatic int unsigned pick_gap(bit calm);
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Hex digit in either letter case.
   function automatic logic [7:0] pick_hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   // Any character that is neither a hex digit nor a slash ('%' included).
   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                 (c >= "A" && c <= "F") || c == upsd_pkg::SplitChar);
      return c;
   endfunction

   // Any byte that passes through as data.
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == upsd_pkg::EscChar || c == upsd_pkg::SplitChar);
      return c;
   endfunction

   task automatic queue_char(logic [7:0] c);
      upsd_pkg::req_type r;
      r.in_byte    = c;
      r.end_of_uri = 1'b0;
      uri_beats    = {uri_beats, r};
   endtask

   task automatic queue_text(string s);
      foreach (s[i]) queue_char(s[i]);
   endtask

   task automatic queue_end(logic [7:0] junk);
      upsd_pkg::req_type r;
      r.in_byte    = junk;
      r.end_of_uri = 1'b1;
      uri_beats    = {uri_beats, r};
   endtask

   // Build one URI: a mix of plain bytes, good and bad escapes and slashes.
   task automatic queue_random_uri();
      int unsigned n_tok;
      int unsigned kind;
      if ($urandom_range(0, 3) == 0) queue_char(upsd_pkg::SplitChar);
      n_tok = $urandom_range(0, 14);
      for (int unsigned k = 0; k < n_tok; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            queue_char(pick_plain());
         end else if (kind < 60) begin
            queue_char(upsd_pkg::EscChar);
            queue_char(pick_hex_char());
            queue_char(pick_hex_char());
         end else if (kind < 66) begin
            // escape with a bad first or second digit
            queue_char(upsd_pkg::EscChar);
            if ($urandom_range(0, 1) == 1) begin
               queue_char(pick_non_hex());
               queue_char(pick_plain());
            end else begin
               queue_char(pick_hex_char());
               queue_char(pick_non_hex());
            end
         end else if (kind < 70) begin
            queue_char(upsd_pkg::EscChar);
            queue_char(upsd_pkg::EscChar);
            queue_char(pick_hex_char());
         end else if (kind < 74) begin
            // escape cut short by a slash
            queue_char(upsd_pkg::EscChar);
            if ($urandom_range(0, 1) == 1) queue_char(pick_hex_char());
            queue_char(upsd_pkg::SplitChar);
         end else if (kind < 88) begin
            queue_char(upsd_pkg::SplitChar);
            if ($urandom_range(0, 5) == 0) queue_char(upsd_pkg::SplitChar);
         end else begin
            queue_char(8'($urandom_range(0, 255)));
         end
      end
      // escape cut short by the end mark
      if ($urandom_range(0, 9) == 0) begin
         queue_char(upsd_pkg::EscChar);
         if ($urandom_range(0, 1) == 1) queue_char(pick_hex_char());
      end
      // leave a few URIs open so the next one runs on into them
      if ($urandom_range(0, 9) != 0) queue_end(8'($urandom_range(0, 255)));
   endtask

   // Present one beat and hold it until the block takes it.
   task automatic send_beat(upsd_pkg::req_type r);
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      board.decode_request(r);
      beats_sent++;
   endtask

   task automatic send_queued();
      int unsigned gap;
      while (uri_beats.size() != 0) begin
         gap = pick_gap(send_calm);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_beat(uri_beats.pop_front());
      end
   endtask

   // Drop push and hold off until every owed byte has come out.
   task automatic drain_wait();
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Response side: take a beat whenever pop and not empty met at the edge,
   // then pick the next pop level with short stalls, a few long ones and
   // calm stretches that pop every cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) board.check_decoded(rsp_data);
         if (pop_calm > 0) begin
            pop_calm--;
            rsp_pop <= 1'b1;
         end else if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_roll = $urandom_range(0, 99);
            if (pop_roll < 25) pop_stall = $urandom_range(1, 3);
            else if (pop_roll < 29) pop_stall = $urandom_range(8, 40);
            else if (pop_roll < 31) pop_calm = $urandom_range(50, 200);
         end
      end
   end

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: hex in both cases, a second '%' as escape digit,
      // escapes cut by the end mark and by a slash, empty elements,
      // extreme byte values and an end mark carrying a junk byte.
      queue_text("A%4F/");
      queue_text("%%41");
      queue_text("%6f%4");
      queue_end(8'h00);
      queue_text("//");
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_end(8'hFF);
      queue_text("%z/");
      queue_end(8'h2F);
      directed_count = uri_beats.size();
      send_queued();
      drain_wait();

      // Random part
      while (beats_sent < directed_count + RandomBeats) begin
         send_calm = ($urandom_range(0, 4) == 0);
         queue_random_uri();
         send_queued();
         // pause the sender once until the block has caught up
         if (!drained_mid && beats_sent >= directed_count + RandomBeats / 2) begin
            drain_wait();
            drained_mid = 1'b1;
         end
      end

      drain_wait();
      repeat (SettleCycles) @(posedge clock);
      if (board.faults == 0 && board.pending() == 0) begin
         $display("uri_path_split_percent_decode verification clean");
      end else begin
         $display("uri_path_split_percent_decode verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> uri_path_split_percent_decode.f
sv/upsd_pkg.sv
sv/upsd_front.sv
sv/upsd_back.sv
sv/uri_path_split_percent_decode.sv
tb/uri_path_split_percent_decode_tb.sv
